// File: src/rfq_pkg.sv
// ----------------------------------------------------------------------------
// rfq_pkg
// Shared types, constants and step functions for the frame to quaternion
// pipeline: digit-serial square root lanes and restoring divider lanes.
// ----------------------------------------------------------------------------
package rfq_pkg;

  localparam int IN_W            = 16;
  localparam int OUT_W           = 16;
  localparam int OUT_FRAC        = 14;
  localparam int NORM_SHIFT      = 30;
  localparam int STEPS_PER_STAGE = 2;
  localparam int ROOT_STEPS      = 32;
  localparam int DIV_STEPS       = 32;
  localparam int ROOT_STAGES     = ROOT_STEPS / STEPS_PER_STAGE;
  localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;
  localparam int MAG_W           = IN_W + 1;

  localparam logic signed [33:0] ONE_Q30 = 34'sd1 <<< NORM_SHIFT;
  localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(1) << OUT_FRAC;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  typedef struct packed {
    logic [63:0] x;
    logic [35:0] rem;
    logic [31:0] root;
  } root_lane_t;

  typedef struct packed {
    logic [63:0] num;
    logic [33:0] rem;
    logic [32:0] den;
    logic [31:0] quot;
  } div_lane_t;

  typedef struct packed {
    logic [8:0]            neg;
    logic [8:0][MAG_W-1:0] mag;
    logic                  zero;
  } col_side_t;

  typedef struct packed {
    branch_t         branch;
    logic            bad;
    logic            zero;
    logic [2:0]      nneg;
    logic [2:0][31:0] nmag;
  } arg_side_t;

  function automatic root_lane_t root_steps(input root_lane_t a);
    root_lane_t  l;
    logic [35:0] rem2;
    logic [35:0] trial;
    l = a;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      rem2  = {l.rem[33:0], l.x[63:62]};
      trial = {2'b00, l.root, 2'b01};
      l.x   = {l.x[61:0], 2'b00};
      if (rem2 >= trial) begin
        l.rem  = rem2 - trial;
        l.root = {l.root[30:0], 1'b1};
      end else begin
        l.rem  = rem2;
        l.root = {l.root[30:0], 1'b0};
      end
    end
    return l;
  endfunction

  function automatic div_lane_t div_steps(input div_lane_t a);
    div_lane_t   l;
    logic [33:0] rem2;
    logic [33:0] dd;
    l = a;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      rem2  = {l.rem[32:0], l.num[63]};
      dd    = {1'b0, l.den};
      l.num = {l.num[62:0], 1'b0};
      if (rem2 >= dd) begin
        l.rem  = rem2 - dd;
        l.quot = {l.quot[30:0], 1'b1};
      end else begin
        l.rem  = rem2;
        l.quot = {l.quot[30:0], 1'b0};
      end
    end
    return l;
  endfunction

endpackage

// File: src/rotation_frame_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_frame_to_quaternion
// Normalizes the three columns of a rotation frame and converts the frame
// to a Q1.14 quaternion with trace or dominant-diagonal branch selection.
//
//   channel | handshake                | beat contents
//   --------+--------------------------+----------------------------------
//   frame   | frame_valid, frame_ready | col0_x .. col2_z, signed 16 bit
//   quat    | quat_valid,  quat_ready  | quat_w .. quat_z, branch, degen
//
// One frame per cycle while quat_ready does not stall the result channel.
// The pipeline holds two 32-step square roots and two 32-step dividers,
// two steps per register stage.
// Reset clears the stage valid bits only.
// Each stage holds while the next one is full and stalled; bubbles close up.
// ----------------------------------------------------------------------------
module rotation_frame_to_quaternion (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    frame_valid,
  output logic                                    frame_ready,
  input  logic signed [rfq_pkg::IN_W-1:0]         col0_x,
  input  logic signed [rfq_pkg::IN_W-1:0]         col0_y,
  input  logic signed [rfq_pkg::IN_W-1:0]         col0_z,
  input  logic signed [rfq_pkg::IN_W-1:0]         col1_x,
  input  logic signed [rfq_pkg::IN_W-1:0]         col1_y,
  input  logic signed [rfq_pkg::IN_W-1:0]         col1_z,
  input  logic signed [rfq_pkg::IN_W-1:0]         col2_x,
  input  logic signed [rfq_pkg::IN_W-1:0]         col2_y,
  input  logic signed [rfq_pkg::IN_W-1:0]         col2_z,
  output logic                                    quat_valid,
  input  logic                                    quat_ready,
  output logic signed [rfq_pkg::OUT_W-1:0]        quat_w,
  output logic signed [rfq_pkg::OUT_W-1:0]        quat_x,
  output logic signed [rfq_pkg::OUT_W-1:0]        quat_y,
  output logic signed [rfq_pkg::OUT_W-1:0]        quat_z,
  output logic [1:0]                              branch_used,
  output logic                                    degenerate
);

  localparam int RS     = rfq_pkg::ROOT_STAGES;
  localparam int DS     = rfq_pkg::DIV_STAGES;
  localparam int S_IN   = 0;
  localparam int S_SQ   = 1;
  localparam int S_LEN  = 2;
  localparam int R1_B   = 3;
  localparam int D1_B   = R1_B + RS;
  localparam int S_N    = D1_B + DS;
  localparam int S_BR   = S_N + 1;
  localparam int R2_B   = S_BR + 1;
  localparam int S_HALF = R2_B + RS;
  localparam int D2_B   = S_HALF + 1;
  localparam int S_OUT  = D2_B + DS;
  localparam int NST    = S_OUT + 1;
  localparam int MW     = rfq_pkg::MAG_W;
  localparam int IW     = rfq_pkg::IN_W;
  localparam int OW     = rfq_pkg::OUT_W;

  // stage valid bits and advance chain
  logic [NST-1:0] v;
  logic [NST-1:0] v_in;
  logic [NST-1:0] en;

  assign en[NST-1] = !v[NST-1] || quat_ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign v_in        = {v[NST-2:0], frame_valid};
  assign frame_ready = en[S_IN];
  assign quat_valid  = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= v_in[k];
        end
      end
    end
  end

  // input capture: signs and magnitudes
  logic signed [IW-1:0] col [9];
  rfq_pkg::col_side_t   in_side;

  assign col[0] = col0_x;
  assign col[1] = col0_y;
  assign col[2] = col0_z;
  assign col[3] = col1_x;
  assign col[4] = col1_y;
  assign col[5] = col1_z;
  assign col[6] = col2_x;
  assign col[7] = col2_y;
  assign col[8] = col2_z;

  always_ff @(posedge clk) begin
    if (en[S_IN]) begin
      for (int a = 0; a < 9; a++) begin
        in_side.neg[a] <= col[a][IW-1];
        in_side.mag[a] <= col[a][IW-1] ? (MW'(0) - MW'(col[a])) : MW'(col[a]);
      end
      in_side.zero <= (col[0] == '0 && col[1] == '0 && col[2] == '0) ||
                      (col[3] == '0 && col[4] == '0 && col[5] == '0) ||
                      (col[6] == '0 && col[7] == '0 && col[8] == '0);
    end
  end

  // squares
  rfq_pkg::col_side_t sq_side;
  logic [2*MW-1:0]    sq_val [9];

  always_ff @(posedge clk) begin
    if (en[S_SQ]) begin
      sq_side <= in_side;
      for (int a = 0; a < 9; a++) begin
        sq_val[a] <= {{MW{1'b0}}, in_side.mag[a]} * {{MW{1'b0}}, in_side.mag[a]};
      end
    end
  end

  // squared column lengths
  rfq_pkg::col_side_t ln_side;
  logic [31:0]        ln_len [3];

  always_ff @(posedge clk) begin
    if (en[S_LEN]) begin
      ln_side <= sq_side;
      for (int c = 0; c < 3; c++) begin
        ln_len[c] <= 32'(sq_val[3*c] + sq_val[3*c+1] + sq_val[3*c+2]);
      end
    end
  end

  // column length roots
  rfq_pkg::root_lane_t r1_src  [RS][3];
  rfq_pkg::root_lane_t r1_lane [RS][3];
  rfq_pkg::col_side_t  r1_ssrc [RS];
  rfq_pkg::col_side_t  r1_side [RS];

  for (genvar g = 0; g < RS; g++) begin : g_r1
    for (genvar c = 0; c < 3; c++) begin : g_lane
      if (g == 0) begin : g_first
        assign r1_src[g][c] = '{x: {2'b00, ln_len[c], 30'b0}, rem: '0, root: '0};
      end else begin : g_next
        assign r1_src[g][c] = r1_lane[g-1][c];
      end
      always_ff @(posedge clk) begin
        if (en[R1_B+g]) begin
          r1_lane[g][c] <= rfq_pkg::root_steps(r1_src[g][c]);
        end
      end
    end
    if (g == 0) begin : g_sfirst
      assign r1_ssrc[g] = ln_side;
    end else begin : g_snext
      assign r1_ssrc[g] = r1_side[g-1];
    end
    always_ff @(posedge clk) begin
      if (en[R1_B+g]) begin
        r1_side[g] <= r1_ssrc[g];
      end
    end
  end

  // component normalization divides
  logic [63:0]        d1_n    [9];
  rfq_pkg::div_lane_t d1_src  [DS][9];
  rfq_pkg::div_lane_t d1_lane [DS][9];
  rfq_pkg::col_side_t d1_ssrc [DS];
  rfq_pkg::col_side_t d1_side [DS];

  for (genvar g = 0; g < DS; g++) begin : g_d1
    for (genvar c = 0; c < 9; c++) begin : g_lane
      if (g == 0) begin : g_first
        assign d1_n[c] = {2'b00, r1_side[RS-1].mag[c], 45'b0} +
                         {33'b0, r1_lane[RS-1][c/3].root[31:1]};
        assign d1_src[g][c] = '{num: {d1_n[c][31:0], 32'b0},
                                rem: {2'b00, d1_n[c][63:32]},
                                den: {1'b0, r1_lane[RS-1][c/3].root},
                                quot: '0};
      end else begin : g_next
        assign d1_src[g][c] = d1_lane[g-1][c];
      end
      always_ff @(posedge clk) begin
        if (en[D1_B+g]) begin
          d1_lane[g][c] <= rfq_pkg::div_steps(d1_src[g][c]);
        end
      end
    end
    if (g == 0) begin : g_sfirst
      assign d1_ssrc[g] = r1_side[RS-1];
    end else begin : g_snext
      assign d1_ssrc[g] = d1_side[g-1];
    end
    always_ff @(posedge clk) begin
      if (en[D1_B+g]) begin
        d1_side[g] <= d1_ssrc[g];
      end
    end
  end

  // signed normalized components, Q2.30
  logic signed [31:0] n_val [9];
  logic               n_zero;

  always_ff @(posedge clk) begin
    if (en[S_N]) begin
      n_zero <= d1_side[DS-1].zero;
      for (int a = 0; a < 9; a++) begin
        n_val[a] <= d1_side[DS-1].neg[a] ? (32'sd0 - $signed(d1_lane[DS-1][a].quot))
                                         : $signed(d1_lane[DS-1][a].quot);
      end
    end
  end

  // branch selection, root argument, numerators
  logic signed [33:0] e [9];
  logic signed [33:0] tr;
  logic signed [33:0] arg_c;
  logic signed [33:0] num_c [3];
  rfq_pkg::branch_t   br_c;

  logic signed [33:0] br_arg;
  logic signed [33:0] br_num [3];
  rfq_pkg::branch_t   br_branch;
  logic               br_zero;

  always_comb begin
    for (int a = 0; a < 9; a++) begin
      e[a] = 34'(n_val[a]);
    end
    tr = e[0] + e[4] + e[8];
    priority if (tr > 0) begin
      br_c = rfq_pkg::BR_TRACE;
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      br_c = rfq_pkg::BR_X;
    end else if (e[4] > e[8]) begin
      br_c = rfq_pkg::BR_Y;
    end else begin
      br_c = rfq_pkg::BR_Z;
    end
    unique case (br_c)
      rfq_pkg::BR_TRACE: begin
        arg_c    = tr + rfq_pkg::ONE_Q30;
        num_c[0] = e[5] - e[7];
        num_c[1] = e[6] - e[2];
        num_c[2] = e[1] - e[3];
      end
      rfq_pkg::BR_X: begin
        arg_c    = rfq_pkg::ONE_Q30 + e[0] - e[4] - e[8];
        num_c[0] = e[5] - e[7];
        num_c[1] = e[3] + e[1];
        num_c[2] = e[6] + e[2];
      end
      rfq_pkg::BR_Y: begin
        arg_c    = rfq_pkg::ONE_Q30 - e[0] + e[4] - e[8];
        num_c[0] = e[6] - e[2];
        num_c[1] = e[3] + e[1];
        num_c[2] = e[7] + e[5];
      end
      default: begin
        arg_c    = rfq_pkg::ONE_Q30 - e[0] - e[4] + e[8];
        num_c[0] = e[1] - e[3];
        num_c[1] = e[6] + e[2];
        num_c[2] = e[7] + e[5];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[S_BR]) begin
      br_arg    <= arg_c;
      br_num    <= num_c;
      br_branch <= br_c;
      br_zero   <= n_zero;
    end
  end

  // quaternion root
  rfq_pkg::arg_side_t  arg_side;
  rfq_pkg::root_lane_t r2_src  [RS];
  rfq_pkg::root_lane_t r2_lane [RS];
  rfq_pkg::arg_side_t  r2_ssrc [RS];
  rfq_pkg::arg_side_t  r2_side [RS];
  logic [33:0]         nabs [3];

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      nabs[p]           = br_num[p][33] ? (34'd0 - br_num[p]) : br_num[p];
      arg_side.nneg[p]  = br_num[p][33];
      arg_side.nmag[p]  = nabs[p][31:0];
    end
    arg_side.branch = br_branch;
    arg_side.bad    = br_arg[33] || (br_arg == '0);
    arg_side.zero   = br_zero;
  end

  for (genvar g = 0; g < RS; g++) begin : g_r2
    if (g == 0) begin : g_first
      assign r2_src[g]  = '{x: {br_arg[33:0], 30'b0}, rem: '0, root: '0};
      assign r2_ssrc[g] = arg_side;
    end else begin : g_next
      assign r2_src[g]  = r2_lane[g-1];
      assign r2_ssrc[g] = r2_side[g-1];
    end
    always_ff @(posedge clk) begin
      if (en[R2_B+g]) begin
        r2_lane[g] <= rfq_pkg::root_steps(r2_src[g]);
        r2_side[g] <= r2_ssrc[g];
      end
    end
  end

  // dominant part and divider operands
  logic [31:0]        r_fin;
  logic [32:0]        half_sum;
  logic [15:0]        half_c;
  logic [OW-1:0]      hf_half;
  logic [63:0]        hf_n [3];
  logic [32:0]        hf_den;
  rfq_pkg::arg_side_t hf_side;

  assign r_fin    = r2_lane[RS-1].root;
  assign half_sum = {1'b0, r_fin} + (33'd1 << (rfq_pkg::NORM_SHIFT - rfq_pkg::OUT_FRAC));
  assign half_c   = 16'(half_sum >> (rfq_pkg::NORM_SHIFT + 1 - rfq_pkg::OUT_FRAC));

  always_ff @(posedge clk) begin
    if (en[S_HALF]) begin
      hf_side <= r2_side[RS-1];
      hf_den  <= {r_fin, 1'b0};
      hf_half <= (half_c > 16'(rfq_pkg::ONE_OUT)) ? OW'(rfq_pkg::ONE_OUT) : OW'(half_c);
      for (int p = 0; p < 3; p++) begin
        hf_n[p] <= {18'b0, r2_side[RS-1].nmag[p], 14'b0} + {32'b0, r_fin};
      end
    end
  end

  // other parts divides
  rfq_pkg::div_lane_t d2_src  [DS][3];
  rfq_pkg::div_lane_t d2_lane [DS][3];
  rfq_pkg::arg_side_t d2_ssrc [DS];
  rfq_pkg::arg_side_t d2_side [DS];
  logic [OW-1:0]      d2_half [DS];
  logic [OW-1:0]      d2_hsrc [DS];

  for (genvar g = 0; g < DS; g++) begin : g_d2
    for (genvar p = 0; p < 3; p++) begin : g_lane
      if (g == 0) begin : g_first
        assign d2_src[g][p] = '{num: {hf_n[p][31:0], 32'b0},
                                rem: {2'b00, hf_n[p][63:32]},
                                den: hf_den,
                                quot: '0};
      end else begin : g_next
        assign d2_src[g][p] = d2_lane[g-1][p];
      end
      always_ff @(posedge clk) begin
        if (en[D2_B+g]) begin
          d2_lane[g][p] <= rfq_pkg::div_steps(d2_src[g][p]);
        end
      end
    end
    if (g == 0) begin : g_sfirst
      assign d2_ssrc[g] = hf_side;
      assign d2_hsrc[g] = hf_half;
    end else begin : g_snext
      assign d2_ssrc[g] = d2_side[g-1];
      assign d2_hsrc[g] = d2_half[g-1];
    end
    always_ff @(posedge clk) begin
      if (en[D2_B+g]) begin
        d2_side[g] <= d2_ssrc[g];
        d2_half[g] <= d2_hsrc[g];
      end
    end
  end

  // apply sign, saturate, place parts
  rfq_pkg::arg_side_t  os;
  logic [OW-1:0]       om [3];
  logic signed [OW-1:0] ov [3];
  logic signed [OW-1:0] oh;
  logic signed [OW-1:0] w_c, x_c, y_c, z_c;

  assign os = d2_side[DS-1];
  assign oh = $signed(d2_half[DS-1]);

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      om[p] = (d2_lane[DS-1][p].quot > 32'(rfq_pkg::ONE_OUT)) ?
              OW'(rfq_pkg::ONE_OUT) : d2_lane[DS-1][p].quot[OW-1:0];
      ov[p] = os.nneg[p] ? $signed(OW'(0) - om[p]) : $signed(om[p]);
    end
    unique case (os.branch)
      rfq_pkg::BR_TRACE: begin
        w_c = oh;    x_c = ov[0]; y_c = ov[1]; z_c = ov[2];
      end
      rfq_pkg::BR_X: begin
        w_c = ov[0]; x_c = oh;    y_c = ov[1]; z_c = ov[2];
      end
      rfq_pkg::BR_Y: begin
        w_c = ov[0]; x_c = ov[1]; y_c = oh;    z_c = ov[2];
      end
      default: begin
        w_c = ov[0]; x_c = ov[1]; y_c = ov[2]; z_c = oh;
      end
    endcase
    if (os.zero || os.bad) begin
      w_c = rfq_pkg::ONE_OUT;
      x_c = '0;
      y_c = '0;
      z_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      quat_w      <= w_c;
      quat_x      <= x_c;
      quat_y      <= y_c;
      quat_z      <= z_c;
      branch_used <= os.zero ? 2'(rfq_pkg::BR_TRACE) : 2'(os.branch);
      degenerate  <= os.zero || os.bad;
    end
  end

`ifndef SYNTHESIS
  a_identity: assert property (@(posedge clk) disable iff (rst)
    quat_valid && degenerate |-> quat_w == rfq_pkg::ONE_OUT && quat_x == '0 &&
                                 quat_y == '0 && quat_z == '0)
    else $error("degenerate beat is not the identity");

  a_range: assert property (@(posedge clk) disable iff (rst)
    quat_valid |-> quat_w <= rfq_pkg::ONE_OUT && quat_w >= -rfq_pkg::ONE_OUT &&
                   quat_x <= rfq_pkg::ONE_OUT && quat_x >= -rfq_pkg::ONE_OUT &&
                   quat_y <= rfq_pkg::ONE_OUT && quat_y >= -rfq_pkg::ONE_OUT &&
                   quat_z <= rfq_pkg::ONE_OUT && quat_z >= -rfq_pkg::ONE_OUT)
    else $error("quaternion part out of range");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !frame_ready |-> v[S_IN] && v[S_OUT])
    else $error("input stalled with a free stage");

  a_take: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_ready |=> v[S_IN])
    else $error("accepted beat dropped at entry");
`endif

endmodule

// File: tb/quat_checker.sv
// ----------------------------------------------------------------------------
// quat_checker
// Watches the frame and quaternion channels, computes the expected
// quaternion of every accepted frame and compares each result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quat_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                frame_valid,
  input  logic                                frame_ready,
  input  logic signed [rfq_pkg::IN_W-1:0]     col0_x,
  input  logic signed [rfq_pkg::IN_W-1:0]     col0_y,
  input  logic signed [rfq_pkg::IN_W-1:0]     col0_z,
  input  logic signed [rfq_pkg::IN_W-1:0]     col1_x,
  input  logic signed [rfq_pkg::IN_W-1:0]     col1_y,
  input  logic signed [rfq_pkg::IN_W-1:0]     col1_z,
  input  logic signed [rfq_pkg::IN_W-1:0]     col2_x,
  input  logic signed [rfq_pkg::IN_W-1:0]     col2_y,
  input  logic signed [rfq_pkg::IN_W-1:0]     col2_z,
  input  logic                                quat_valid,
  input  logic                                quat_ready,
  input  logic signed [rfq_pkg::OUT_W-1:0]    quat_w,
  input  logic signed [rfq_pkg::OUT_W-1:0]    quat_x,
  input  logic signed [rfq_pkg::OUT_W-1:0]    quat_y,
  input  logic signed [rfq_pkg::OUT_W-1:0]    quat_z,
  input  logic [1:0]                          branch_used,
  input  logic                                degenerate,
  output int                                  fail_count,
  output int                                  pending_quats
);

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    rfq_pkg::branch_t   br;
    logic               degen;
  } quat_t;

  quat_t expected_quats[$];

  assign pending_quats = expected_quats.size();

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint scaled_div(input longint num, input logic [63:0] den,
                                        input int sh);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (num < 0) ? -num : num;
    q   = ((mag << sh) + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_unit(input longint v);
    longint unit;
    unit = longint'(1) << rfq_pkg::OUT_FRAC;
    if (v > unit) return unit;
    if (v < -unit) return -unit;
    return v;
  endfunction

  // normalize one column to Q2.30; zero-length column returns 0
  function automatic bit unit_column(input longint c0, input longint c1, input longint c2,
                                     output longint n[3]);
    logic [63:0] len2;
    logic [63:0] s;
    if (c0 == 0 && c1 == 0 && c2 == 0) return 0;
    len2 = c0 * c0 + c1 * c1 + c2 * c2;
    s    = int_sqrt(len2 << rfq_pkg::NORM_SHIFT);
    n[0] = scaled_div(c0, s, 45);
    n[1] = scaled_div(c1, s, 45);
    n[2] = scaled_div(c2, s, 45);
    return 1;
  endfunction

  function automatic quat_t frame_to_quat(input longint c[9]);
    longint i[3], j[3], k[3];
    longint q[4];
    longint nums[3];
    longint unity, arg, tr, half;
    logic [63:0] r;
    int p;
    rfq_pkg::branch_t br;
    quat_t res;
    unity = longint'(1) << rfq_pkg::NORM_SHIFT;
    q[0] = longint'(1) << rfq_pkg::OUT_FRAC;
    q[1] = 0; q[2] = 0; q[3] = 0;
    br = rfq_pkg::BR_TRACE;
    res.degen = 0;
    if (!unit_column(c[0], c[1], c[2], i) || !unit_column(c[3], c[4], c[5], j) ||
        !unit_column(c[6], c[7], c[8], k)) begin
      res.degen = 1;
    end else begin
      tr = i[0] + j[1] + k[2];
      if (tr > 0) begin
        br = rfq_pkg::BR_TRACE;
        arg = tr + unity;
        nums[0] = j[2] - k[1]; nums[1] = k[0] - i[2]; nums[2] = i[1] - j[0];
      end else if (i[0] > j[1] && i[0] > k[2]) begin
        br = rfq_pkg::BR_X;
        arg = unity + i[0] - j[1] - k[2];
        nums[0] = j[2] - k[1]; nums[1] = j[0] + i[1]; nums[2] = k[0] + i[2];
      end else if (j[1] > k[2]) begin
        br = rfq_pkg::BR_Y;
        arg = unity - i[0] + j[1] - k[2];
        nums[0] = k[0] - i[2]; nums[1] = j[0] + i[1]; nums[2] = k[1] + j[2];
      end else begin
        br = rfq_pkg::BR_Z;
        arg = unity - i[0] - j[1] + k[2];
        nums[0] = i[1] - j[0]; nums[1] = k[0] + i[2]; nums[2] = k[1] + j[2];
      end
      if (arg <= 0) begin
        res.degen = 1;
      end else begin
        r = int_sqrt(64'(arg) << rfq_pkg::NORM_SHIFT);
        half = longint'((r + (64'd1 << (30 - rfq_pkg::OUT_FRAC))) >>
                        (31 - rfq_pkg::OUT_FRAC));
        q[int'(br)] = clamp_unit(half);
        p = 0;
        for (int a = 0; a < 4; a++) begin
          if (a != int'(br)) begin
            q[a] = clamp_unit(scaled_div(nums[p], 2 * r, rfq_pkg::OUT_FRAC));
            p++;
          end
        end
      end
    end
    res.w = q[0][15:0];
    res.x = q[1][15:0];
    res.y = q[2][15:0];
    res.z = q[3][15:0];
    res.br = br;
    return res;
  endfunction

  always @(posedge clk) begin
    longint c[9];
    quat_t e;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (frame_valid && frame_ready) begin
        c = '{col0_x, col0_y, col0_z, col1_x, col1_y, col1_z, col2_x, col2_y, col2_z};
        expected_quats.push_back(frame_to_quat(c));
      end
      if (quat_valid && quat_ready) begin
        if (expected_quats.size() == 0) begin
          $display("%0t: unexpected beat w=%0d x=%0d y=%0d z=%0d br=%0d dg=%0d", $time,
                   quat_w, quat_x, quat_y, quat_z, branch_used, degenerate);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_quats.pop_front();
          if (e.w !== quat_w || e.x !== quat_x || e.y !== quat_y || e.z !== quat_z ||
              e.br !== branch_used || e.degen !== degenerate) begin
            $display("%0t: expected w=%0d x=%0d y=%0d z=%0d br=%0d dg=%0d", $time,
                     e.w, e.x, e.y, e.z, e.br, e.degen);
            $display("%0t: actual   w=%0d x=%0d y=%0d z=%0d br=%0d dg=%0d", $time,
                     quat_w, quat_x, quat_y, quat_z, branch_used, degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives frames into the frame to quaternion pipeline with random idling,
// back-pressure and a drain pause; the checker scores every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_RANDOM  = 1630;
  localparam int WATCH_LIMIT = 5000;

  logic clk = 0;
  logic rst = 1;
  logic frame_valid = 0;
  logic frame_ready;
  logic signed [15:0] col[9];
  logic quat_valid;
  logic quat_ready = 0;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  logic [1:0] branch_used;
  logic degenerate;
  int fail_count;
  int pending_quats;
  bit quiet_phase = 0;
  bit hold_off = 0;
  int idle_cycles = 0;

  initial for (int a = 0; a < 9; a++) col[a] = 0;

  always #2 clk = ~clk;

  rotation_frame_to_quaternion dut (
    .clk(clk), .rst(rst), .frame_valid(frame_valid), .frame_ready(frame_ready),
    .col0_x(col[0]), .col0_y(col[1]), .col0_z(col[2]),
    .col1_x(col[3]), .col1_y(col[4]), .col1_z(col[5]),
    .col2_x(col[6]), .col2_y(col[7]), .col2_z(col[8]),
    .quat_valid(quat_valid), .quat_ready(quat_ready),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .branch_used(branch_used), .degenerate(degenerate)
  );

  quat_checker checker_i (
    .clk(clk), .rst(rst), .frame_valid(frame_valid), .frame_ready(frame_ready),
    .col0_x(col[0]), .col0_y(col[1]), .col0_z(col[2]),
    .col1_x(col[3]), .col1_y(col[4]), .col1_z(col[5]),
    .col2_x(col[6]), .col2_y(col[7]), .col2_z(col[8]),
    .quat_valid(quat_valid), .quat_ready(quat_ready),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .branch_used(branch_used), .degenerate(degenerate),
    .fail_count(fail_count), .pending_quats(pending_quats)
  );

  // receiver: random stall bursts, a long hold-off on request, none at the end
  always @(posedge clk) begin
    int stall;
    if (rst) begin
      quat_ready <= 0;
    end else if (hold_off) begin
      quat_ready <= 0;
    end else if (quiet_phase) begin
      quat_ready <= 1;
    end else if ($urandom_range(0, 9) < 2) begin
      stall = $urandom_range(1, 7);
      quat_ready <= 0;
      repeat (stall) @(posedge clk);
      quat_ready <= 1;
    end else begin
      quat_ready <= 1;
    end
  end

  initial begin
    #1;
    forever begin
      @(posedge clk);
      if ((frame_valid && frame_ready) || (quat_valid && quat_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_frame(input logic signed [15:0] f[9]);
    int gap;
    if (!quiet_phase && $urandom_range(0, 9) < 2) begin
      gap = $urandom_range(1, 7);
      frame_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    frame_valid <= 1;
    for (int a = 0; a < 9; a++) col[a] <= f[a];
    @(posedge clk);
    while (!frame_ready) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 6)) - 16'sd3;
      default: return 16'($urandom);
    endcase
  endfunction

  // rotation about a random axis pair, scaled, with small jitter
  function automatic void rand_rotation(output logic signed [15:0] f[9]);
    real ang, cs, sn, sc;
    real m[9];
    int ax;
    ang = ($urandom_range(0, 62831) / 10000.0);
    cs = $cos(ang); sn = $sin(ang);
    sc = $urandom_range(1, 32000);
    ax = $urandom_range(0, 2);
    m = '{1.0, 0.0, 0.0, 0.0, 1.0, 0.0, 0.0, 0.0, 1.0};
    case (ax)
      0: begin m[4] = cs; m[5] = sn; m[7] = -sn; m[8] = cs; end
      1: begin m[0] = cs; m[2] = -sn; m[6] = sn; m[8] = cs; end
      default: begin m[0] = cs; m[1] = sn; m[3] = -sn; m[4] = cs; end
    endcase
    for (int a = 0; a < 9; a++)
      f[a] = 16'($rtoi(m[a] * sc) + $urandom_range(0, 2) - 1);
  endfunction

  initial begin
    logic signed [15:0] f[9];
    logic signed [15:0] directed[20][9];
    directed = '{
      '{16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1},
      '{16'sh7fff, 0, 0, 0, 16'sh7fff, 0, 0, 0, 16'sh7fff},
      '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh7fff},
      '{16'sd100, 0, 0, 0, -16'sd100, 0, 0, 0, -16'sd100},
      '{-16'sd100, 0, 0, 0, 16'sd100, 0, 0, 0, -16'sd100},
      '{-16'sd100, 0, 0, 0, -16'sd100, 0, 0, 0, 16'sd100},
      '{-16'sd1, 0, 0, 0, -16'sd1, 0, 0, 0, -16'sd1},
      '{0, 0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1},
      '{16'sd1, 0, 0, 0, 0, 0, 0, 0, 16'sd1},
      '{16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, 0},
      '{16'sd1, 0, 0, 16'sd1, 0, 0, 16'sd1, 0, 0},
      '{-16'sd1, 16'sd1, 0, 16'sd1, -16'sd1, 0, 0, 0, -16'sd1},
      '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
        16'sh8000, 16'sh7fff, 16'sh8000},
      '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
        16'sh7fff, 16'sh7fff, 16'sh7fff},
      '{0, 16'sd5, 0, -16'sd5, 0, 0, 0, 0, 16'sd5},
      '{0, 0, 16'sd9, 0, 16'sd9, 0, -16'sd9, 0, 0},
      '{16'sd3, 16'sd4, 0, -16'sd4, 16'sd3, 0, 0, 0, 16'sd5},
      '{-16'sd1, 0, 0, 0, -16'sd1, 0, 0, 0, 16'sd1},
      '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
        16'sh5555, 16'shaaaa, 16'sh5555},
      '{16'sd1, 0, 0, 0, -16'sd1, 0, 0, 0, -16'sd1}
    };
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[d]) begin
      for (int a = 0; a < 9; a++) f[a] = directed[d][a];
      send_frame(f);
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 300) begin
        hold_off = 1;
        fork
          begin
            repeat (200) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      if (n == 700) begin
        frame_valid <= 0;
        @(posedge clk);
        while (pending_quats != 0) @(posedge clk);
      end
      if (n == NUM_RANDOM - 150) quiet_phase = 1;
      if ($urandom_range(0, 9) < 7) begin
        rand_rotation(f);
      end else begin
        for (int a = 0; a < 9; a++) f[a] = rand_word();
      end
      send_frame(f);
    end
    frame_valid <= 0;
    quiet_phase = 1;
    @(posedge clk);
    while (pending_quats != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
